// ----- sv/tpps_pkg.sv -----
// Package for the timer prescaler / period search block.
// Holds widths, search limits, status and state codes, controller/datapath structs.
// No dependencies.
package tpps_pkg;

  localparam int CLK_W  = 32;
  localparam int FREQ_W = 16;
  localparam int PSC_W  = 11;
  localparam int PER_W  = 16;
  localparam int STAT_W = 2;
  localparam int DIVS_W = 16;                 // divisor width of the shared divider
  localparam int CNT_W  = $clog2(CLK_W);      // one quotient bit per step

  localparam logic [CLK_W-1:0]  CLOCK_RESET  = 32'd72000000;
  localparam logic [PSC_W-1:0]  PSC_MAX      = 11'd1200;
  localparam logic [CLK_W-1:0]  PERIOD_LIMIT = 32'd65535;
  localparam logic [FREQ_W-1:0] ROUND_THR    = 16'd32768;

  typedef enum logic [STAT_W-1:0] {
    STAT_EXACT = 2'd0,
    STAT_TRUNC = 2'd1,
    STAT_NONE  = 2'd2,
    STAT_ZERO  = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_QDIV,
    ST_PSTART,
    ST_PDIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;     // latch the incoming request
    logic write_cfg;  // load source clock register
    logic set_zero;   // zero frequency: no search
    logic start_q;    // launch source_clock / frequency
    logic take_q;     // store rounded count, restart prescaler scan
    logic start_p;    // launch count / prescaler
    logic judge;      // score the current prescaler
    logic inc_p;      // move to next prescaler
    logic publish;    // load output register and saved pair
  } dp_cmd_t;

  typedef struct packed {
    logic freq_zero;
    logic div_done;
    logic per_ok;
    logic rem_zero;
    logic p_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- sv/timer_prescaler_period_search.sv -----
// Top level of the timer prescaler / period search block.
// Joins tpps_ctrl and tpps_datapath; depends on tpps_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall, frequency): one request per wanted PWM
//   frequency. Output channel (out_valid / out_stall): prescaler, period, status.
//   Config channel (cfg_valid / cfg_ready, cfg_data): source clock in hertz;
//   cfg_ready is high only while no request is in progress.
// Operation:
//   count = source_clock / frequency, rounded up when the remainder exceeds
//   32768. Prescalers 1..1200 are scanned in order; the first that divides the
//   count exactly with period below 65535 wins (status 0), else the first with
//   period below 65535 is used (status 1). With no split (status 2) or zero
//   frequency (status 3) the previous pair is repeated.
// Flow:
//   One request at a time through a shared 1-bit-per-cycle divider.
//   Zero frequency goes straight to the output register. Otherwise one
//   rounding divide, then one divide per prescaler tried (1..1200).
//   in_stall is low only in idle; the next request is taken while the last
//   result still waits in the output register.
// Reset: synchronous; clock register returns to 72 MHz, saved pair to (1, 0),
//   output empty. A stalled result holds; a finished search waits for the slot.
module timer_prescaler_period_search import tpps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FREQ_W-1:0] frequency,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PSC_W-1:0]  prescaler,
  output logic [PER_W-1:0]  period,
  output logic [STAT_W-1:0] status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CLK_W-1:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tpps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpps_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_data  (cfg_data),
    .frequency (frequency),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .prescaler (prescaler),
    .period    (period),
    .status    (status)
  );

endmodule

// ----- sv/tpps_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// 32-bit dividend by 16-bit divisor in 32 steps; done pulses after the last.
// Depends on tpps_pkg.
module tpps_div import tpps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CLK_W-1:0]  dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [CLK_W-1:0]  quot,
  output logic [DIVS_W-1:0] rem
);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W:0]   shifted;
  logic              ge;
  logic [DIVS_W:0]   diff;

  always_comb begin
    shifted = {rem, quot[CLK_W-1]};
    ge      = (shifted >= {1'b0, dvs});
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CLK_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (run) begin
      quot <= {quot[CLK_W-2:0], ge};
      rem  <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
    end
  end

endmodule

// ----- sv/tpps_datapath.sv -----
// Datapath: source clock register, count and prescaler scan registers,
// candidate pair, saved pair and output register; uses the shared divider.
// Depends on tpps_pkg and tpps_div.
module tpps_datapath import tpps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [CLK_W-1:0]  cfg_data,
  input  logic [FREQ_W-1:0] frequency,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PSC_W-1:0]  prescaler,
  output logic [PER_W-1:0]  period,
  output logic [STAT_W-1:0] status
);

  logic [CLK_W-1:0]  clk_hz;
  logic [FREQ_W-1:0] freq;
  logic [CLK_W-1:0]  q;
  logic [PSC_W-1:0]  p;
  logic [PSC_W-1:0]  cand_psc;
  logic [PER_W-1:0]  cand_per;
  stat_t             cand_stat;
  logic [PSC_W-1:0]  last_psc;
  logic [PER_W-1:0]  last_per;

  logic              div_start;
  logic [CLK_W-1:0]  div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_done;
  logic [CLK_W-1:0]  div_quot;
  logic [DIVS_W-1:0] div_rem;
  logic              pair_new;

  assign div_start    = cmd.start_q | cmd.start_p;
  assign div_dividend = cmd.start_q ? clk_hz : q;
  assign div_divisor  = cmd.start_q ? freq : DIVS_W'(p);

  tpps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign stat.freq_zero = (freq == '0);
  assign stat.div_done  = div_done;
  assign stat.per_ok    = (div_quot < PERIOD_LIMIT);
  assign stat.rem_zero  = (div_rem == '0);
  assign stat.p_last    = (p == PSC_MAX);
  assign stat.out_busy  = out_valid & out_stall;

  assign pair_new = (cand_stat == STAT_EXACT) || (cand_stat == STAT_TRUNC);

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz    <= CLOCK_RESET;
      last_psc  <= PSC_W'(1);
      last_per  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.write_cfg) begin
        clk_hz <= cfg_data;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
        if (pair_new) begin
          last_psc <= cand_psc;
          last_per <= cand_per;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      freq <= frequency;
    end
    if (cmd.set_zero) begin
      cand_stat <= STAT_ZERO;
    end
    if (cmd.take_q) begin
      // round up when the remainder is above half of the 16-bit range
      q         <= div_quot + CLK_W'(div_rem > ROUND_THR);
      p         <= PSC_W'(1);
      cand_stat <= STAT_NONE;
    end
    if (cmd.inc_p) begin
      p <= p + 1'b1;
    end
    // remainder is below p <= 1200, so the truncated split needs no remainder test
    if (cmd.judge && stat.per_ok) begin
      if (stat.rem_zero) begin
        cand_psc  <= p;
        cand_per  <= div_quot[PER_W-1:0];
        cand_stat <= STAT_EXACT;
      end else if (cand_stat == STAT_NONE) begin
        cand_psc  <= p;
        cand_per  <= div_quot[PER_W-1:0];
        cand_stat <= STAT_TRUNC;
      end
    end
    if (cmd.publish) begin
      prescaler <= pair_new ? cand_psc : last_psc;
      period    <= pair_new ? cand_per : last_per;
      status    <= cand_stat;
    end
  end

endmodule

// ----- sv/tpps_ctrl.sv -----
// Controller state machine: sequences rounding divide, prescaler scan and publish.
// Drives the datapath by command struct; depends on tpps_pkg.
module tpps_ctrl import tpps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   search_end;

  assign search_end = stat.div_done & ((stat.per_ok & stat.rem_zero) | stat.p_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = stat.freq_zero ? ST_FINISH : ST_QDIV;
      ST_QDIV:   if (stat.div_done) state_next = ST_PSTART;
      ST_PSTART: state_next = ST_PDIV;
      ST_PDIV: begin
        if (search_end) begin
          state_next = ST_FINISH;
        end else if (stat.div_done) begin
          state_next = ST_PSTART;
        end
      end
      ST_FINISH: if (!stat.out_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cfg_ready     = 1'b1;
        cmd.accept    = in_valid;
        cmd.write_cfg = cfg_valid;
      end
      ST_LAUNCH: begin
        cmd.set_zero = stat.freq_zero;
        cmd.start_q  = ~stat.freq_zero;
      end
      ST_QDIV:   cmd.take_q  = stat.div_done;
      ST_PSTART: cmd.start_p = 1'b1;
      ST_PDIV: begin
        cmd.judge = stat.div_done;
        cmd.inc_p = stat.div_done & ~search_end;
      end
      ST_FINISH: cmd.publish = ~stat.out_busy;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- sv/tpps_checker.sv -----
// Port-level checker for timer_prescaler_period_search, bound to the top level.
// Depends on tpps_pkg.
module tpps_checker import tpps_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [PSC_W-1:0]  prescaler,
  input logic [PER_W-1:0]  period,
  input logic [STAT_W-1:0] status,
  input logic              cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && !cfg_ready))
    else $error("request accepted but block not busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(prescaler) && $stable(period)
                                  && $stable(status)))
    else $error("stalled result changed");

  a_psc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (prescaler != '0 && prescaler <= PSC_MAX))
    else $error("prescaler out of range");

  a_per_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (period != '1))
    else $error("period at limit");

endmodule

bind timer_prescaler_period_search tpps_checker u_tpps_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking bench for timer_prescaler_period_search: drives frequency requests,
// predicts prescaler/period/status per request and checks every result in order.
// Depends on tpps_pkg and the timer_prescaler_period_search RTL only.
module tb_top;
  import tpps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Remainder bound of the truncated search; never binds at the block's sizes.
  localparam longint unsigned REM_LIMIT = 32758;
  // Requests that try more prescalers than this count as slow.
  localparam int FAST_TRIES = 40;
  // Slow requests allowed in the random part, on top of the four directed ones.
  localparam int SLOW_RANDOM = 6;
  // Random requests per clock setting; with the directed ones about a hundred.
  localparam int RAND_PER_PHASE = 16;
  // Long receiver hold-off, long enough for the block to back up its input.
  localparam int HOLD_CYCLES = 300;
  // Slowest correct run: ten slow requests plus short requests, gaps and
  // stalls. Take it several times.
  localparam int LIMIT_CYCLES = 2_000_000;

  typedef struct {
    logic [PSC_W-1:0] psc;
    logic [PER_W-1:0] per;
    stat_t            st;
    int               tries;
  } split_t;

  typedef struct {
    logic [FREQ_W-1:0] freq;
    logic [PSC_W-1:0]  psc;
    logic [PER_W-1:0]  per;
    stat_t             st;
  } pwm_split_t;

  // DUT ports, all inputs known from time zero
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FREQ_W-1:0] frequency = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PSC_W-1:0]  prescaler;
  logic [PER_W-1:0]  period;
  logic [STAT_W-1:0] status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CLK_W-1:0]  cfg_data = '0;

  // Bench state
  logic [FREQ_W-1:0] freq_q[$];          // requests waiting for the driver
  pwm_split_t        split_expect_q[$];  // predicted results, oldest first
  logic [CLK_W-1:0]  clock_hz = CLOCK_RESET;  // bench copy of the clock register
  logic [PSC_W-1:0]  last_psc = 11'd1;   // bench copy of the saved pair
  logic [PER_W-1:0]  last_per = '0;
  bit                idle_on = 1'b1;     // random gaps on both sides
  bit                hold_req = 1'b0;
  bit                hold_off = 1'b0;
  int                tx_wait = 0;
  int                rx_wait = 0;
  int                slow_budget = SLOW_RANDOM;
  int                mismatches = 0;
  int                results_checked = 0;
  int                requests_sent = 0;
  int                clock_writes = 0;
  int                stat_seen[4] = '{0, 0, 0, 0};

  timer_prescaler_period_search uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Search predictor: rounded count, then the first exact split, else the
  // first truncated one, scanning prescalers upward. tries is the scan length,
  // which is what sets the block's run time.
  function automatic split_t find_split(logic [CLK_W-1:0] clk_hz, logic [FREQ_W-1:0] f);
    split_t          res;
    longint unsigned q, r, per, rem;
    bit              have_trunc;
    res.psc = '0;
    res.per = '0;
    res.st = STAT_NONE;
    res.tries = 0;
    have_trunc = 1'b0;
    if (f == '0) begin
      res.st = STAT_ZERO;
      return res;
    end
    q = clk_hz / f;
    r = clk_hz % f;
    if (r > ROUND_THR) q++;
    for (int p = 1; p <= int'(PSC_MAX); p++) begin
      per = q / p;
      rem = q % p;
      if (per < PERIOD_LIMIT) begin
        if (rem == 0) begin
          res.psc = PSC_W'(p);
          res.per = PER_W'(per);
          res.st = STAT_EXACT;
          res.tries = p;
          return res;
        end
        if (!have_trunc && rem < REM_LIMIT) begin
          have_trunc = 1'b1;
          res.psc = PSC_W'(p);
          res.per = PER_W'(per);
        end
      end
    end
    res.tries = int'(PSC_MAX);
    res.st = have_trunc ? STAT_TRUNC : STAT_NONE;
    return res;
  endfunction

  function automatic int pick_gap();
    return idle_on ? $urandom_range(0, 8) : 0;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Wait until every queued request went in and every result came out.
  task automatic wait_drain();
    do @(negedge clk);
    while (freq_q.size() != 0 || in_valid || split_expect_q.size() != 0);
  endtask

  // Config write; only called with the block idle, so cfg_ready comes quickly.
  task automatic write_clock(logic [CLK_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    clock_hz = v;
    clock_writes++;
  endtask

  // Random requests for the current clock. A quarter of them lean to low
  // frequencies where the search runs long; slow ones are rationed so the run
  // stays short, the rest are redrawn.
  task automatic add_random(int n);
    logic [FREQ_W-1:0] f;
    split_t            sp;
    repeat (n) begin
      do begin
        case ($urandom_range(0, 19))
          0:       f = '0;
          1, 2, 3,
          4, 5:    f = FREQ_W'($urandom_range(1, 2000));
          default: f = FREQ_W'($urandom_range(0, 65535));
        endcase
        sp = find_split(clock_hz, f);
      end while (sp.tries > FAST_TRIES && slow_budget == 0);
      if (sp.tries > FAST_TRIES) slow_budget--;
      freq_q.push_back(f);
    end
  endtask

  // Request driver: holds a stalled request, otherwise waits out its drawn gap
  // and presents the next one. Back-to-back requests keep in_valid high.
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else if (!(in_valid && in_stall)) begin
      gap = in_valid ? pick_gap() : tx_wait;
      if (gap == 0 && freq_q.size() != 0) begin
        frequency <= freq_q.pop_front();
        in_valid <= 1'b1;
        tx_wait <= 0;
      end else begin
        in_valid <= 1'b0;
        tx_wait <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  // Result receiver: after each taken result it stalls for a drawn number of
  // cycles; the hold-off process can force a long stall on top.
  always @(posedge clk) begin
    int w;
    if (rst) begin
      rx_wait <= 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) w = pick_gap();
      else w = (rx_wait > 0) ? rx_wait - 1 : 0;
      rx_wait <= w;
      out_stall <= (w != 0) || hold_off;
    end
  end

  // Long hold-off, counted here on its own: the sender keeps offering, the
  // block takes one request past the parked result and then stalls its input.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Monitor: predicts on every taken request, checks every taken result.
  always @(posedge clk) begin
    split_t     sp;
    pwm_split_t e;
    if (rst) begin
      last_psc = 11'd1;
      last_per = '0;
    end else begin
      if (in_valid && !in_stall) begin
        sp = find_split(clock_hz, frequency);
        // A found split replaces the saved pair; none or zero echoes it.
        if (sp.st == STAT_EXACT || sp.st == STAT_TRUNC) begin
          last_psc = sp.psc;
          last_per = sp.per;
        end
        e.freq = frequency;
        e.psc = last_psc;
        e.per = last_per;
        e.st = sp.st;
        split_expect_q.push_back(e);
        requests_sent++;
        stat_seen[sp.st]++;
      end
      if (out_valid && !out_stall) begin
        if (split_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result psc=%0d per=%0d status=%0d",
                                    prescaler, period, status));
        end else begin
          e = split_expect_q.pop_front();
          results_checked++;
          if (prescaler !== e.psc || period !== e.per || status !== e.st)
            report_mismatch($sformatf("freq %0d clk %0d: got %0d/%0d/%0d want %0d/%0d/%0d",
                                      e.freq, clock_hz, prescaler, period, status,
                                      e.psc, e.per, e.st));
        end
      end
    end
  end

  // Watchdog
  initial begin
    int cycle_cnt;
    for (cycle_cnt = 0; cycle_cnt < LIMIT_CYCLES; cycle_cnt++) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, split_expect_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset clock (72 MHz): zero frequency before any split, the longest exact
    // search (1 Hz), rounding up at the top frequency, p=1 edges around 1099,
    // then zero again to echo the last pair.
    freq_q = '{16'd0, 16'd1, 16'd65535, 16'd1099, 16'd1098, 16'd1000, 16'd32768,
               16'd50000, 16'd7, 16'd0};
    wait_drain();

    // Zero clock: count is zero, prescaler 1 period 0 for any frequency.
    write_clock('0);
    freq_q = '{16'd1, 16'd65535, 16'd0};
    wait_drain();

    // Full-scale clock: no split at 1 Hz, truncated split on the prime count
    // 65537, zero after a failed search, exact split at p=3 after rounding.
    write_clock('1);
    freq_q = '{16'd1, 16'd0, 16'd65535, 16'd60000};
    wait_drain();

    // One-hertz clock: counts 1 and 0, rounding never fires.
    write_clock(32'd1);
    freq_q = '{16'd1, 16'd2, 16'd65535};
    wait_drain();

    // Random part, one clock setting per phase. The first phase runs without
    // gaps and with the long hold-off so the block backs up.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       write_clock(CLOCK_RESET);
        1:       write_clock($urandom());
        2:       write_clock($urandom_range(1, 200_000_000));
        3:       write_clock($urandom_range(1, 65535));
        default: write_clock($urandom());
      endcase
      idle_on = (ph != 0);
      if (ph == 0) hold_req = 1'b1;
      add_random(RAND_PER_PHASE);
      wait_drain();
    end

    // Zero frequency is the shortest path; an idle tail catches strays.
    repeat (50) @(posedge clk);

    $display("Ran %0d requests over %0d clock settings, %0d results checked.",
             requests_sent, clock_writes + 1, results_checked);
    $display("Status mix exact/truncated/none/zero: %0d/%0d/%0d/%0d, mismatches %0d.",
             stat_seen[STAT_EXACT], stat_seen[STAT_TRUNC], stat_seen[STAT_NONE],
             stat_seen[STAT_ZERO], mismatches);
    if (mismatches == 0 && split_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- timer_prescaler_period_search.f -----
sv/tpps_pkg.sv
sv/tpps_div.sv
sv/tpps_datapath.sv
sv/tpps_ctrl.sv
sv/timer_prescaler_period_search.sv
sv/tpps_checker.sv
sim/tb_top.sv
